// ===== sv/plq_pkg.sv =====
`default_nettype none
package plq_pkg;

	// Slot store geometry
	localparam int SLOTS      = 255;
	localparam int SLOT_W     = 8;
	localparam int MAX_EVENTS = 63;
	localparam int EV_W       = 6;

	localparam logic [SLOT_W-1:0] SLOT_NONE = 8'hFF;

	// Input kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FILL   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Result kinds
	localparam logic [2:0] RES_INSERTED  = 3'd0;
	localparam logic [2:0] RES_FULL      = 3'd1;
	localparam logic [2:0] RES_CANCELLED = 3'd2;
	localparam logic [2:0] RES_REJECTED  = 3'd3;
	localparam logic [2:0] RES_FILL      = 3'd4;
	localparam logic [2:0] RES_CLOSING   = 3'd5;

	// Register indexes
	localparam logic REG_LEVEL_PRICE  = 1'b0;
	localparam logic REG_RESTING_SIDE = 1'b1;

	localparam logic [7:0] FILL_TYPE = 8'd1;

	typedef struct packed {
		logic [31:0]       order_id;
		logic [15:0]       quantity;
		logic [SLOT_W-1:0] next;
		logic [SLOT_W-1:0] prev;
	} slot_entry_t;

	typedef struct packed {
		logic order_id;
		logic quantity;
		logic next;
		logic prev;
	} slot_wen_t;

	typedef struct packed {
		logic [2:0]        result_kind;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       event_order_id;
		logic [15:0]       event_quantity;
		logic [31:0]       event_price;
		logic              event_side;
		logic [7:0]        event_type;
		logic              order_done;
		logic [23:0]       level_total;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/plq_slot_ram.sv =====
`default_nettype none
module plq_slot_ram (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [plq_pkg::SLOT_W-1:0] rd_addr,
	output plq_pkg::slot_entry_t            rd_data,
	input  wire plq_pkg::slot_wen_t         wen,
	input  wire logic [plq_pkg::SLOT_W-1:0] wr_addr,
	input  wire plq_pkg::slot_entry_t       wr_data
);
	import plq_pkg::*;

	slot_entry_t mem [SLOTS];

	// Write the enabled fields of one entry
	always_ff @(posedge clk) begin
		if (wen.order_id) mem[wr_addr].order_id <= wr_data.order_id;
		if (wen.quantity) mem[wr_addr].quantity <= wr_data.quantity;
		if (wen.next)     mem[wr_addr].next     <= wr_data.next;
		if (wen.prev)     mem[wr_addr].prev     <= wr_data.prev;
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== sv/plq_free_stack.sv =====
`default_nettype none
module plq_free_stack (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	output logic [plq_pkg::SLOT_W-1:0]      rd_data,
	input  wire logic                       pop,
	input  wire logic                       push,
	input  wire logic [plq_pkg::SLOT_W-1:0] push_slot,
	output logic [plq_pkg::SLOT_W-1:0]      top
);
	import plq_pkg::*;

	logic [SLOT_W-1:0] mem [SLOTS];
	logic [SLOT_W-1:0] top_q;
	logic [SLOT_W-1:0] hwm_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              rd_fresh_q;
	logic [SLOT_W-1:0] rd_mem_q;
	logic [SLOT_W-1:0] top_dec;

	assign top_dec = top_q - 1'b1;
	assign top     = top_q;

	// Entries at or above the high-water mark were never written and hold their index
	assign rd_data = rd_fresh_q ? rd_idx_q : rd_mem_q;

	// Track stack pointer and high-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			hwm_q <= '0;
		end else if (pop) begin
			top_q <= top_q + 1'b1;
			if (top_q >= hwm_q) hwm_q <= top_q + 1'b1;
		end else if (push) begin
			top_q <= top_dec;
		end
	end

	// Store freed slots
	always_ff @(posedge clk) begin
		if (push) mem[top_dec] <= push_slot;
	end

	// Read the entry at the top
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mem_q   <= mem[top_q];
			rd_idx_q   <= top_q;
			rd_fresh_q <= (top_q >= hwm_q);
		end
	end

endmodule
`default_nettype wire

// ===== sv/plq_ctrl.sv =====
`default_nettype none
module plq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [31:0]                level_price,
	input  wire logic                       resting_side,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 kind,
	input  wire logic [31:0]                order_id,
	input  wire logic [15:0]                order_quantity,
	input  wire logic [31:0]                order_price,
	input  wire logic [7:0]                 order_type,
	input  wire logic [7:0]                 cancel_slot,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output plq_pkg::result_t                res,
	output logic                            ram_rd_en,
	output logic [plq_pkg::SLOT_W-1:0]      ram_rd_addr,
	input  wire plq_pkg::slot_entry_t       ram_rd_data,
	output plq_pkg::slot_wen_t              ram_wen,
	output logic [plq_pkg::SLOT_W-1:0]      ram_wr_addr,
	output plq_pkg::slot_entry_t            ram_wr_data,
	output logic                            fs_rd_en,
	input  wire logic [plq_pkg::SLOT_W-1:0] fs_rd_data,
	output logic                            fs_pop,
	output logic                            fs_push,
	output logic [plq_pkg::SLOT_W-1:0]      fs_push_slot,
	input  wire logic [plq_pkg::SLOT_W-1:0] fs_top
);
	import plq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INS_RD, ST_INS_LINK, ST_CAN_RD, ST_UNL_P, ST_UNL_N,
		ST_F_CHK, ST_F_RD, ST_F_EV1, ST_F_EV2, ST_F_CLOSE, ST_RES
	} state_t;

	state_t            state_q, ret_q;
	logic [31:0]       id_q, price_q;
	logic [15:0]       qty_q;
	logic [7:0]        type_q;
	logic [23:0]       total_q, fin_total_q;
	logic [SLOT_W-1:0] head_q, tail_q, cur_q, s_q, nxt_q, prv_q;
	logic [SLOTS-1:0]  in_use_q;
	logic [15:0]       rem_q, nq_q, f_q;
	logic [31:0]       rid_q;
	logic [EV_W-1:0]   events_q;
	logic [2:0]        res_kind_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [31:0]       res_id_q;
	logic [15:0]       res_qty_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              out_free, cancel_ok, full, walk_go, ev_room, res_load;
	logic [15:0]       fill_f;
	logic [23:0]       consumed;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (fs_top == SLOT_W'(SLOTS));
	assign cancel_ok = (cancel_slot != SLOT_NONE) && in_use_q[cancel_slot];
	assign walk_go   = (cur_q != SLOT_NONE) && (rem_q != '0);
	assign ev_room   = (events_q < EV_W'(MAX_EVENTS));
	assign fill_f    = (rem_q < ram_rd_data.quantity) ? rem_q : ram_rd_data.quantity;
	// The queue holds every live order, so a fill takes min(quantity, total)
	assign consumed  = ({8'd0, order_quantity} < total_q) ? {8'd0, order_quantity}
		: total_q;
	// Load a new result into the output register this cycle
	assign res_load  = out_free && ((((state_q == ST_F_EV1) || (state_q == ST_F_EV2))
		&& ev_room) || (state_q == ST_F_CLOSE) || (state_q == ST_RES));

	// Drive memory and free stack accesses
	always_comb begin
		ram_rd_en    = 1'b0;
		ram_rd_addr  = cur_q;
		ram_wen      = '0;
		ram_wr_addr  = cur_q;
		ram_wr_data  = '0;
		fs_rd_en     = 1'b0;
		fs_pop       = 1'b0;
		fs_push      = 1'b0;
		fs_push_slot = s_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && kind == KIND_INSERT && !full) fs_rd_en = 1'b1;
				if (in_valid && kind == KIND_CANCEL && cancel_ok) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = cancel_slot;
				end
			end
			ST_INS_RD: begin
				ram_wen     = '1;
				ram_wr_addr = fs_rd_data;
				ram_wr_data = '{order_id: id_q, quantity: qty_q, next: SLOT_NONE,
					prev: tail_q};
				fs_pop      = 1'b1;
			end
			ST_INS_LINK: begin
				ram_wen.next     = 1'b1;
				ram_wr_addr      = tail_q;
				ram_wr_data.next = s_q;
			end
			ST_UNL_P: begin
				ram_wen.next     = (prv_q != SLOT_NONE);
				ram_wr_addr      = prv_q;
				ram_wr_data.next = nxt_q;
			end
			ST_UNL_N: begin
				ram_wen.prev     = (nxt_q != SLOT_NONE);
				ram_wr_addr      = nxt_q;
				ram_wr_data.prev = prv_q;
				fs_push          = (fs_top != '0);
			end
			ST_F_CHK: begin
				ram_rd_en = walk_go;
			end
			ST_F_RD: begin
				ram_wen.quantity     = 1'b1;
				ram_wr_data.quantity = ram_rd_data.quantity - fill_f;
			end
			default: ;
		endcase
	end

	// Sequence the operations and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
			in_use_q    <= '0;
			head_q      <= SLOT_NONE;
			tail_q      <= SLOT_NONE;
			total_q     <= '0;
			fin_total_q <= '0;
			events_q    <= '0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q        <= order_id;
						qty_q       <= order_quantity;
						price_q     <= order_price;
						type_q      <= order_type;
						fin_total_q <= (kind == KIND_FILL) ? total_q - consumed : total_q;
						case (kind)
							KIND_INSERT: begin
								if (full) begin
									res_kind_q <= RES_FULL;
									res_slot_q <= SLOT_NONE;
									res_id_q   <= order_id;
									res_qty_q  <= order_quantity;
									state_q    <= ST_RES;
								end else begin
									state_q <= ST_INS_RD;
								end
							end
							KIND_CANCEL: begin
								s_q <= cancel_slot;
								if (cancel_ok) begin
									state_q <= ST_CAN_RD;
								end else begin
									res_kind_q <= RES_REJECTED;
									res_slot_q <= cancel_slot;
									res_id_q   <= '0;
									res_qty_q  <= '0;
									state_q    <= ST_RES;
								end
							end
							KIND_FILL: begin
								cur_q    <= head_q;
								rem_q    <= order_quantity;
								events_q <= '0;
								state_q  <= ST_F_CHK;
							end
							default: ;
						endcase
					end
				end
				ST_INS_RD: begin
					in_use_q[fs_rd_data] <= 1'b1;
					total_q              <= total_q + {8'd0, qty_q};
					fin_total_q          <= total_q + {8'd0, qty_q};
					res_kind_q           <= RES_INSERTED;
					res_slot_q           <= fs_rd_data;
					res_id_q             <= id_q;
					res_qty_q            <= qty_q;
					s_q                  <= fs_rd_data;
					if (tail_q == SLOT_NONE) begin
						head_q  <= fs_rd_data;
						tail_q  <= fs_rd_data;
						state_q <= ST_RES;
					end else begin
						state_q <= ST_INS_LINK;
					end
				end
				ST_INS_LINK: begin
					tail_q  <= s_q;
					state_q <= ST_RES;
				end
				ST_CAN_RD: begin
					total_q     <= total_q - {8'd0, ram_rd_data.quantity};
					fin_total_q <= total_q - {8'd0, ram_rd_data.quantity};
					res_kind_q  <= RES_CANCELLED;
					res_slot_q  <= s_q;
					res_id_q    <= ram_rd_data.order_id;
					res_qty_q   <= ram_rd_data.quantity;
					nxt_q       <= ram_rd_data.next;
					prv_q       <= ram_rd_data.prev;
					ret_q       <= ST_RES;
					state_q     <= ST_UNL_P;
				end
				ST_UNL_P: begin
					if (prv_q == SLOT_NONE) head_q <= nxt_q;
					state_q <= ST_UNL_N;
				end
				ST_UNL_N: begin
					if (nxt_q == SLOT_NONE) tail_q <= prv_q;
					in_use_q[s_q] <= 1'b0;
					state_q       <= ret_q;
				end
				ST_F_CHK: begin
					state_q <= walk_go ? ST_F_RD : ST_F_CLOSE;
				end
				ST_F_RD: begin
					f_q     <= fill_f;
					nq_q    <= ram_rd_data.quantity - fill_f;
					rem_q   <= rem_q - fill_f;
					total_q <= total_q - {8'd0, fill_f};
					nxt_q   <= ram_rd_data.next;
					prv_q   <= ram_rd_data.prev;
					rid_q   <= ram_rd_data.order_id;
					state_q <= ST_F_EV1;
				end
				ST_F_EV1: begin
					if (!ev_room) begin
						state_q <= ST_F_EV2;
					end else if (out_free) begin
						res_q    <= '{RES_FILL, cur_q, rid_q, f_q, level_price,
							resting_side, FILL_TYPE, (nq_q == '0), fin_total_q, 1'b0};
						events_q <= events_q + 1'b1;
						state_q  <= ST_F_EV2;
					end
				end
				ST_F_EV2: begin
					if (!ev_room || out_free) begin
						if (ev_room) begin
							res_q    <= '{RES_FILL, SLOT_NONE, id_q, f_q, level_price,
								!resting_side, FILL_TYPE, (rem_q == '0), fin_total_q, 1'b0};
							events_q <= events_q + 1'b1;
						end
						cur_q <= nxt_q;
						if (nq_q == '0) begin
							s_q     <= cur_q;
							ret_q   <= ST_F_CHK;
							state_q <= ST_UNL_P;
						end else begin
							state_q <= ST_F_CHK;
						end
					end
				end
				ST_F_CLOSE: begin
					if (out_free) begin
						res_q   <= '{RES_CLOSING, SLOT_NONE, id_q, rem_q, price_q,
							!resting_side, type_q, (rem_q == '0), fin_total_q, 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_RES: begin
					if (out_free) begin
						res_q   <= '{res_kind_q, res_slot_q, res_id_q, res_qty_q, 32'd0,
							1'b0, 8'd0, 1'b0, fin_total_q, 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/price_level_order_queue.sv =====
`default_nettype none
// Channel  Direction  Handshake          Payload
// cfg      in         cfg_wr_en          cfg_index, cfg_data
// in       in         in_valid/in_stall  kind, order_id, order_quantity, order_price,
//                                        order_type, cancel_slot
// out      out        out_valid/out_stall result_kind, slot, event_order_id, ...
//
// One item at a time: the input stays stalled until the item is done. Each
// match of a fill is a read-modify-write of the slot memory, plus link updates
// when the order is removed, through its single write port. Reset clears the
// queue at once; the free stack uses a high-water mark instead of a clearing
// pass. A stalled output holds the sequencer only when it has a new result to
// load.
module price_level_order_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] order_id,
	input  wire logic [15:0] order_quantity,
	input  wire logic [31:0] order_price,
	input  wire logic [7:0]  order_type,
	input  wire logic [7:0]  cancel_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_kind,
	output logic [7:0]       slot,
	output logic [31:0]      event_order_id,
	output logic [15:0]      event_quantity,
	output logic [31:0]      event_price,
	output logic             event_side,
	output logic [7:0]       event_type,
	output logic             order_done,
	output logic [23:0]      level_total,
	output logic             last
);
	import plq_pkg::*;

	logic [31:0]       level_price_q;
	logic              resting_side_q;
	result_t           res;
	logic              ram_rd_en;
	logic [SLOT_W-1:0] ram_rd_addr, ram_wr_addr;
	slot_entry_t       ram_rd_data, ram_wr_data;
	slot_wen_t         ram_wen;
	logic              fs_rd_en, fs_pop, fs_push;
	logic [SLOT_W-1:0] fs_rd_data, fs_push_slot, fs_top;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_price_q  <= '0;
			resting_side_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LEVEL_PRICE:  level_price_q  <= cfg_data;
				REG_RESTING_SIDE: resting_side_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	plq_slot_ram u_ram (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.wen     (ram_wen),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	plq_free_stack u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (fs_rd_en),
		.rd_data   (fs_rd_data),
		.pop       (fs_pop),
		.push      (fs_push),
		.push_slot (fs_push_slot),
		.top       (fs_top)
	);

	plq_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.level_price    (level_price_q),
		.resting_side   (resting_side_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.order_id       (order_id),
		.order_quantity (order_quantity),
		.order_price    (order_price),
		.order_type     (order_type),
		.cancel_slot    (cancel_slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.res            (res),
		.ram_rd_en      (ram_rd_en),
		.ram_rd_addr    (ram_rd_addr),
		.ram_rd_data    (ram_rd_data),
		.ram_wen        (ram_wen),
		.ram_wr_addr    (ram_wr_addr),
		.ram_wr_data    (ram_wr_data),
		.fs_rd_en       (fs_rd_en),
		.fs_rd_data     (fs_rd_data),
		.fs_pop         (fs_pop),
		.fs_push        (fs_push),
		.fs_push_slot   (fs_push_slot),
		.fs_top         (fs_top)
	);

	// Unpack the result register onto the ports
	assign result_kind    = res.result_kind;
	assign slot           = res.slot;
	assign event_order_id = res.event_order_id;
	assign event_quantity = res.event_quantity;
	assign event_price    = res.event_price;
	assign event_side     = res.event_side;
	assign event_type     = res.event_type;
	assign order_done     = res.order_done;
	assign level_total    = res.level_total;
	assign last           = res.last;

endmodule
`default_nettype wire

// ===== bench/plq_checker.sv =====
`default_nettype none
module plq_checker (
	input  wire logic        clk,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] order_id,
	input  wire logic [15:0] order_quantity,
	input  wire logic [31:0] order_price,
	input  wire logic [7:0]  order_type,
	input  wire logic [7:0]  cancel_slot,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  result_kind,
	input  wire logic [7:0]  slot,
	input  wire logic [31:0] event_order_id,
	input  wire logic [15:0] event_quantity,
	input  wire logic [31:0] event_price,
	input  wire logic        event_side,
	input  wire logic [7:0]  event_type,
	input  wire logic        order_done,
	input  wire logic [23:0] level_total,
	input  wire logic        last,
	output int               fail_count,
	output int               pending,
	output int               results_seen
);
	import plq_pkg::*;

	// Shadow copy of the price level
	logic [15:0]       lvl_qty  [SLOTS];
	logic [31:0]       lvl_id   [SLOTS];
	logic [SLOT_W-1:0] lvl_next [SLOTS];
	logic [SLOT_W-1:0] lvl_prev [SLOTS];
	bit                lvl_used [SLOTS];
	logic [SLOT_W-1:0] free_slots [SLOTS];
	int                free_top;
	logic [SLOT_W-1:0] head;
	logic [SLOT_W-1:0] tail;
	logic [23:0]       resting_total;
	logic [31:0]       price_reg;
	logic              side_reg;

	result_t expected_q[$];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			lvl_used[i] = 1'b0;
			free_slots[i] = SLOT_W'(i);
		end
		free_top = 0;
		head = SLOT_NONE;
		tail = SLOT_NONE;
		resting_total = '0;
		price_reg = '0;
		side_reg = 1'b0;
		fail_count = 0;
		pending = 0;
		results_seen = 0;
	end

	function automatic result_t make_result(logic [2:0] rk, logic [7:0] s, logic [31:0] id,
			logic [15:0] q, logic [31:0] p, logic sd, logic [7:0] t, logic dn);
		result_t r;
		r.result_kind = rk;
		r.slot = s;
		r.event_order_id = id;
		r.event_quantity = q;
		r.event_price = p;
		r.event_side = sd;
		r.event_type = t;
		r.order_done = dn;
		r.level_total = '0;
		r.last = 1'b0;
		return r;
	endfunction

	// Unlink a slot and push it back on the free stack
	task automatic release_slot(logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] p;
		logic [SLOT_W-1:0] n;
		p = lvl_prev[s];
		n = lvl_next[s];
		if (p != SLOT_NONE) lvl_next[p] = n; else head = n;
		if (n != SLOT_NONE) lvl_prev[n] = p; else tail = p;
		lvl_used[s] = 1'b0;
		if (free_top > 0) begin
			free_top--;
			free_slots[free_top] = s;
		end
	endtask

	// Work out the results of one accepted item
	task automatic predict_results(logic [1:0] k, logic [31:0] id, logic [15:0] q,
			logic [31:0] p, logic [7:0] t, logic [7:0] cs);
		result_t batch[$];
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] cur;
		logic [SLOT_W-1:0] nxt;
		logic [15:0] rem;
		logic [15:0] nq;
		logic [15:0] f;
		int events;
		int guard;
		result_t r;
		case (k)
			KIND_INSERT: begin
				if (free_top >= SLOTS) begin
					batch.push_back(make_result(RES_FULL, SLOT_NONE, id, q, 0, 0, 0, 0));
				end else begin
					s = free_slots[free_top];
					free_top++;
					lvl_qty[s] = q;
					lvl_id[s] = id;
					lvl_next[s] = SLOT_NONE;
					lvl_prev[s] = SLOT_NONE;
					lvl_used[s] = 1'b1;
					resting_total = resting_total + 24'(q);
					if (tail != SLOT_NONE) begin
						lvl_next[tail] = s;
						lvl_prev[s] = tail;
						tail = s;
					end else begin
						head = s;
						tail = s;
					end
					batch.push_back(make_result(RES_INSERTED, s, id, q, 0, 0, 0, 0));
				end
			end
			KIND_CANCEL: begin
				if (cs < SLOTS && lvl_used[cs]) begin
					batch.push_back(make_result(RES_CANCELLED, cs, lvl_id[cs], lvl_qty[cs],
						0, 0, 0, 0));
					resting_total = resting_total - 24'(lvl_qty[cs]);
					release_slot(cs);
				end else begin
					batch.push_back(make_result(RES_REJECTED, cs, 0, 0, 0, 0, 0, 0));
				end
			end
			KIND_FILL: begin
				cur = head;
				rem = q;
				guard = 0;
				events = 0;
				while (cur != SLOT_NONE && lvl_used[cur] && rem > 0 && guard < SLOTS) begin
					nxt = lvl_next[cur];
					nq = lvl_qty[cur];
					f = (rem < nq) ? rem : nq;
					nq = nq - f;
					rem = rem - f;
					lvl_qty[cur] = nq;
					resting_total = resting_total - 24'(f);
					// drop events past the cap, keep matching
					if (events < MAX_EVENTS) begin
						batch.push_back(make_result(RES_FILL, cur, lvl_id[cur], f, price_reg,
							side_reg, FILL_TYPE, nq == 0));
						events++;
					end
					if (events < MAX_EVENTS) begin
						batch.push_back(make_result(RES_FILL, SLOT_NONE, id, f, price_reg,
							~side_reg, FILL_TYPE, rem == 0));
						events++;
					end
					if (nq == 0) release_slot(cur);
					cur = nxt;
					guard++;
				end
				batch.push_back(make_result(RES_CLOSING, SLOT_NONE, id, rem, p, ~side_reg, t,
					rem == 0));
			end
			default: ;
		endcase
		foreach (batch[i]) begin
			r = batch[i];
			r.level_total = resting_total;
			r.last = (i == batch.size() - 1);
			expected_q.push_back(r);
		end
	endtask

	task automatic report(string msg);
		if (fail_count < 40) $display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("result %0d field %s got %0h want %0h", results_seen, name,
				got, want));
	endtask

	always @(posedge clk) begin
		result_t want;
		// track register writes
		if (cfg_wr_en) begin
			if (cfg_index == REG_LEVEL_PRICE) price_reg <= cfg_data;
			else side_reg <= cfg_data[0];
		end
		// predict on input transfer
		if (in_valid && !in_stall)
			predict_results(kind, order_id, order_quantity, order_price, order_type,
				cancel_slot);
		// compare on output transfer
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = expected_q.pop_front();
				check_field("result_kind", result_kind, want.result_kind);
				check_field("slot", slot, want.slot);
				check_field("event_order_id", event_order_id, want.event_order_id);
				check_field("event_quantity", event_quantity, want.event_quantity);
				check_field("event_price", event_price, want.event_price);
				check_field("event_side", event_side, want.event_side);
				check_field("event_type", event_type, want.event_type);
				check_field("order_done", order_done, want.order_done);
				check_field("level_total", level_total, want.level_total);
				check_field("last", last, want.last);
			end
			results_seen++;
		end
		pending = expected_q.size();
	end

endmodule
`default_nettype wire

// ===== bench/tb_price_level_order_queue.sv =====
`default_nettype none
module tb_price_level_order_queue;
	import plq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_INSERT;
	logic [31:0] order_id = '0;
	logic [15:0] order_quantity = '0;
	logic [31:0] order_price = '0;
	logic [7:0]  order_type = '0;
	logic [7:0]  cancel_slot = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [7:0]  slot;
	logic [31:0] event_order_id;
	logic [15:0] event_quantity;
	logic [31:0] event_price;
	logic        event_side;
	logic [7:0]  event_type;
	logic        order_done;
	logic [23:0] level_total;
	logic        last;

	int fail_count;
	int pending;
	int results_seen;
	int items_sent = 0;
	int cycle_count = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	bit quiet = 1'b0;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int SETTLE = 40;

	price_level_order_queue DUT (.*);

	plq_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: random stall, a long hold on request, none while quiet
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
		end
	end

	// Write both registers while the block is idle
	task automatic write_config(logic [31:0] price, logic side);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LEVEL_PRICE;
		cfg_data <= price;
		@(posedge clk);
		cfg_index <= REG_RESTING_SIDE;
		cfg_data <= {31'd0, side};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one item and hold it until the transfer
	task automatic send_item(logic [1:0] k, logic [31:0] id, logic [15:0] q,
			logic [31:0] p, logic [7:0] t, logic [7:0] cs);
		while (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		order_id <= id;
		order_quantity <= q;
		order_price <= p;
		order_type <= t;
		cancel_slot <= cs;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic random_item();
		int pick;
		logic [15:0] q;
		logic [7:0] cs;
		pick = $urandom_range(99);
		q = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		cs = ($urandom_range(3) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 254));
		if (pick < 48)
			send_item(KIND_INSERT, $urandom, q, $urandom, 8'($urandom),
				8'($urandom_range(0, 254)));
		else if (pick < 72)
			send_item(KIND_CANCEL, $urandom, 16'($urandom), $urandom, 8'($urandom), cs);
		else if (pick < 97)
			send_item(KIND_FILL, $urandom, 16'(q * 2), $urandom, 8'($urandom),
				8'($urandom_range(0, 254)));
		else
			send_item(KIND_UNUSED, $urandom, 16'($urandom), $urandom, 8'($urandom),
				8'($urandom_range(0, 254)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty level, extremes, zero quantities, rejects, ignored kind
		write_config(32'h1234_5678, 1'b0);
		send_item(KIND_FILL, 32'hA, 16'd100, 32'h55, 8'h7, 8'd0);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 8'h0, 8'd0);
		send_item(KIND_INSERT, 32'h0, 16'h0, 32'h0, 8'h0, 8'd0);
		send_item(KIND_INSERT, 32'h5, 16'd10, 32'h0, 8'h0, 8'd0);
		send_item(KIND_FILL, 32'hB, 16'd0, 32'h1, 8'h2, 8'd0);
		send_item(KIND_CANCEL, 32'h0, 16'h0, 32'h0, 8'h0, 8'd200);
		send_item(KIND_CANCEL, 32'h0, 16'h0, 32'h0, 8'h0, 8'd254);
		send_item(KIND_CANCEL, 32'h0, 16'h0, 32'h0, 8'h0, 8'd0);
		send_item(KIND_CANCEL, 32'h0, 16'h0, 32'h0, 8'h0, 8'd0);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'd254);
		send_item(KIND_FILL, 32'hC, 16'd4, 32'h3, 8'h4, 8'd0);
		send_item(KIND_INSERT, 32'h7, 16'd3, 32'h0, 8'h0, 8'd0);
		send_item(KIND_INSERT, 32'h8, 16'd9, 32'h0, 8'h0, 8'd0);
		send_item(KIND_FILL, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);

		// Fill the level to capacity, hit full, then sweep it past the event cap
		write_config(32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < SLOTS + 1; i++)
			send_item(KIND_INSERT, $urandom, 16'($urandom_range(1, 200)), 0, 0, 0);
		send_item(KIND_CANCEL, 0, 0, 0, 0, 8'd254);
		send_item(KIND_CANCEL, 0, 0, 0, 0, 8'd0);
		send_item(KIND_INSERT, $urandom, 16'd50, 0, 0, 0);
		send_item(KIND_INSERT, $urandom, 16'd60, 0, 0, 0);
		send_item(KIND_INSERT, $urandom, 16'd70, 0, 0, 0);
		send_item(KIND_FILL, $urandom, 16'hFFFF, $urandom, 8'($urandom), 0);

		// Random traffic with settings changed between phases
		write_config(32'h0, 1'b0);
		for (int i = 0; i < 134; i++) begin
			if (i == 30) hold_req = hold_req + 1;
			if (i == 60) quiet = 1'b1;
			if (i == 100) quiet = 1'b0;
			if (i % 50 == 49) write_config($urandom, 1'($urandom_range(1)));
			random_item();
		end
		in_valid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d items, checked %0d results", items_sent, results_seen);
		$display("covered full level, event cap, cancels, zero quantities, long hold");
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/plq_pkg.sv
sv/plq_slot_ram.sv
sv/plq_free_stack.sv
sv/plq_ctrl.sv
sv/price_level_order_queue.sv
bench/plq_checker.sv
bench/tb_price_level_order_queue.sv
